// ----- src/urfm_pkg.sv -----
// urfm_pkg: shared types, codes and defaults for the uart receive frame manager
// no dependencies; imported by every module of the block but urfm_ram

package urfm_pkg;

    // default line buffer depth in bytes
    localparam int unsigned URFM_BUFFER_DEPTH = 256;

    // configuration port widths
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // request opcodes
    typedef enum logic [1:0] {
        OP_RX_BYTE   = 2'd0,
        OP_TICK      = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } opcode_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BRIDGE_PORT = 2'd0,
        REG_TERM_ENABLE = 2'd1,
        REG_TERM_CHAR   = 2'd2,
        REG_IDLE_TICKS  = 2'd3
    } cfg_index_t;

    // input request payload
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } in_t;

    // result payload
    typedef struct packed {
        logic       forward_valid;
        logic [1:0] forward_port;
        logic [7:0] forward_byte;
        logic       frame_done;
        logic [8:0] fill_count;
        logic       restart_timer;
        logic       overflow;
        logic [7:0] read_data;
    } out_t;

    // configuration register file
    typedef struct packed {
        logic [1:0]  bridge_port;
        logic        terminator_enable;
        logic [7:0]  terminator_char;
        logic [15:0] idle_ticks;
    } cfg_t;

    // result from the update stage; read data is filled in from the buffer later
    typedef struct packed {
        out_t payload;
        logic rd_sel;
    } res_t;

endpackage

// ----- src/uart_rx_frame_manager.sv -----
// uart_rx_frame_manager: receive message framer for one serial channel
// depends on urfm_pkg, urfm_ram, urfm_ctrl and urfm_out
//
// Usage: each input request is one event (received byte, timer tick, clear of
// the done flag, or line buffer read) on the in_valid/in_stall channel. Every
// request gives exactly one result on out_valid/out_stall, in order.
// Path: a result passes the read stage, which holds it while the line buffer
// ram read is registered, and then the output register.
// Throughput: one request per cycle while in_stall is low. Message state is
// updated and the buffer is written in the cycle a request is accepted, so
// consecutive requests see each other's effects with no interlock.
// Stalling: a read stage and an output register form two slots, so a request
// is still taken while one result waits; in_stall rises only when both are
// full and out_stall is high.
// Configuration: cfg_we writes register cfg_index with cfg_data at a clock
// edge; write only while no requests are in flight.
// Reset: rst_n clears the registers, the count, the done flag and the idle
// counter at once; the buffer is not cleared, so the user must read it only
// where written; the block itself does not enforce this.

module uart_rx_frame_manager
    import urfm_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = URFM_BUFFER_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_t                   out_data
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    logic          accept;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    res_t          res;

    // request handshake
    assign accept = in_valid && !in_stall;

    // state update and buffer access
    urfm_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req       (in_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res       (res)
    );

    // line buffer
    urfm_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result staging and output register
    urfm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .res       (res),
        .mem_rdata (mem_rdata),
        .busy      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- src/urfm_ram.sv -----
// urfm_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module urfm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/urfm_ctrl.sv -----
// urfm_ctrl: configuration registers, message state and line buffer access
// depends on urfm_pkg; drives the write and read ports of urfm_ram

module urfm_ctrl
    import urfm_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = URFM_BUFFER_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [CFG_INDEX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    input  logic                            accept,
    input  in_t                             req,
    output logic                            mem_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] mem_waddr,
    output logic [7:0]                      mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0] mem_raddr,
    output res_t                            res
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned IW = (AW > 8) ? AW : 8;

    cfg_t           cfg_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic           done_reg, done_next;
    logic [15:0]    idle_reg, idle_next;

    logic           room;
    logic           restart;
    logic           ovf;
    logic           fwd;
    logic [IW:0]    idx_ext;
    logic           idx_ok;
    logic [CW+8:0]  count_ext;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_BRIDGE_PORT: cfg_reg.bridge_port       <= cfg_data[1:0];
                REG_TERM_ENABLE: cfg_reg.terminator_enable <= cfg_data[0];
                REG_TERM_CHAR:   cfg_reg.terminator_char   <= cfg_data[7:0];
                REG_IDLE_TICKS:  cfg_reg.idle_ticks        <= cfg_data;
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // buffer read index range check
    assign idx_ext = (IW + 1)'(req.read_index);
    assign idx_ok  = idx_ext < (IW + 1)'(BUFFER_DEPTH);
    assign room    = count_reg < CW'(BUFFER_DEPTH);
    assign fwd     = cfg_reg.bridge_port != 2'd0;

    // next message state
    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        idle_next  = idle_reg;
        restart    = 1'b0;
        ovf        = 1'b0;
        case (opcode_t'(req.opcode))
            OP_RX_BYTE:
            begin
                if (!fwd)
                begin
                    if (cfg_reg.terminator_enable)
                    begin
                        if (req.rx_byte == cfg_reg.terminator_char)
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        else if (room)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf = 1'b1;
                        end
                    end
                    else
                    begin
                        if (room)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf = 1'b1;
                        end
                        idle_next = cfg_reg.idle_ticks;
                        restart   = 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (count_reg != '0)
                begin
                    if (idle_reg == 16'd0)
                    begin
                        count_next = '0;
                        done_next  = 1'b1;
                        restart    = 1'b1;
                    end
                    else
                    begin
                        idle_next = idle_reg - 16'd1;
                    end
                end
            end
            OP_CLEAR:
            begin
                done_next = 1'b0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // state registers, updated per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            idle_reg  <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            idle_reg  <= idle_next;
        end
    end

    // line buffer write at the current count, read at the request index
    assign mem_we    = accept && (opcode_t'(req.opcode) == OP_RX_BYTE) && !fwd && room;
    assign mem_waddr = count_reg[AW-1:0];
    assign mem_wdata = req.rx_byte;
    assign mem_re    = accept;
    assign mem_raddr = idx_ext[AW-1:0];

    // result fields except the buffer data
    assign count_ext = (CW + 9)'(count_next);

    always_comb
    begin
        res.payload.forward_valid = 1'b0;
        res.payload.forward_port  = 2'd0;
        res.payload.forward_byte  = 8'd0;
        if ((opcode_t'(req.opcode) == OP_RX_BYTE) && fwd)
        begin
            res.payload.forward_valid = 1'b1;
            res.payload.forward_port  = cfg_reg.bridge_port;
            res.payload.forward_byte  = req.rx_byte;
        end
        res.payload.frame_done    = done_next;
        res.payload.fill_count    = count_ext[8:0];
        res.payload.restart_timer = restart;
        res.payload.overflow      = ovf;
        res.payload.read_data     = 8'd0;
        res.rd_sel                = (opcode_t'(req.opcode) == OP_READ) && idx_ok;
    end

endmodule

// ----- src/urfm_out.sv -----
// urfm_out: read-data stage and output register with two-entry buffering
// depends on urfm_pkg; takes the buffer read data from urfm_ram

module urfm_out
    import urfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  res_t       res,
    input  logic [7:0] mem_rdata,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data
);

    logic s1_valid_reg, s1_valid_next;
    res_t s1_reg;
    logic out_valid_reg, out_valid_next;
    out_t out_reg, out_next;
    logic out_free;
    logic s1_move;

    // handoff between stages
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign busy     = s1_valid_reg && !out_free;

    // valid bits
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // merge buffer data into the result
    always_comb
    begin
        out_next           = s1_reg.payload;
        out_next.read_data = s1_reg.rd_sel ? mem_rdata : 8'd0;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= res;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- verif/uart_rx_frame_manager_tb.sv -----
// uart_rx_frame_manager_tb: self-checking bench for the receive frame manager
// drives byte, tick, clear and read requests with random idling and checks every
// result against an in-bench framer model or a typed table result; depends on urfm_pkg

module uart_rx_frame_manager_tb;
    import urfm_pkg::*;

    localparam int unsigned DEPTH = URFM_BUFFER_DEPTH;
    localparam int QUIET_LIMIT = 5000;
    localparam int SEGMENTS = 12;
    localparam int SEGMENT_REQUESTS = 95;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_CHECK,
        ROW_FIXED
    } row_kind_t;

    // one directed step: a register write or a request with an optional typed result
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  code;
        logic [15:0] value;
        logic [7:0]  index;
        logic        done;
        logic [8:0]  count;
        logic        restart;
        logic [7:0]  rdata;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 27;

    // directed steps; typed results only where they follow at a glance
    localparam stim_row_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        // defaults after reset: idle mode, zero idle ticks
        '{ROW_FIXED, OP_TICK,    16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_FIXED, OP_CLEAR,   16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_FIXED, OP_RX_BYTE, 16'h0000, 8'hFF, 1'b0, 9'd1, 1'b1, 8'h00},
        '{ROW_FIXED, OP_RX_BYTE, 16'h00FF, 8'h00, 1'b0, 9'd2, 1'b1, 8'h00},
        '{ROW_FIXED, OP_READ,    16'h00FF, 8'h00, 1'b0, 9'd2, 1'b0, 8'h00},
        '{ROW_FIXED, OP_READ,    16'h0000, 8'h01, 1'b0, 9'd2, 1'b0, 8'hFF},
        // idle counter already zero, so the first tick ends the message
        '{ROW_FIXED, OP_TICK,    16'h0000, 8'h00, 1'b1, 9'd0, 1'b1, 8'h00},
        '{ROW_FIXED, OP_CLEAR,   16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        // idle timeout after two countdown ticks
        '{ROW_CFG,   REG_IDLE_TICKS,  16'h0002, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_RX_BYTE, 16'h005A, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_TICK,    16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_TICK,    16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_TICK,    16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        // terminator mode with carriage return
        '{ROW_CFG,   REG_TERM_ENABLE, 16'h0001, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CFG,   REG_TERM_CHAR,   16'h000D, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_RX_BYTE, 16'h0041, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_FIXED, OP_RX_BYTE, 16'h000D, 8'h00, 1'b1, 9'd0, 1'b0, 8'h00},
        '{ROW_FIXED, OP_READ,    16'h0000, 8'h01, 1'b1, 9'd0, 1'b0, 8'h0D},
        '{ROW_CHECK, OP_TICK,    16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_CLEAR,   16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        // tick timeout also applies in terminator mode
        '{ROW_CHECK, OP_RX_BYTE, 16'h0080, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_TICK,    16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        // bridge mode forwards and leaves the buffer alone
        '{ROW_CFG,   REG_BRIDGE_PORT, 16'h0003, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_RX_BYTE, 16'h00C3, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_RX_BYTE, 16'h000D, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CHECK, OP_READ,    16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00},
        '{ROW_CFG,   REG_BRIDGE_PORT, 16'h0000, 8'h00, 1'b0, 9'd0, 1'b0, 8'h00}
    };

    // block ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_t                    in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_t                   out_data;

    // framer model state and register copy
    logic [1:0]  cfg_bridge = '0;
    logic        cfg_term_en = 1'b0;
    logic [7:0]  cfg_term_char = '0;
    logic [15:0] cfg_idle_ticks = '0;
    logic [8:0]  fill = '0;
    logic        done = 1'b0;
    logic [15:0] idle_cnt = '0;
    logic [7:0]  line_mem [DEPTH];
    int          written_top = 0;

    // bench bookkeeping
    out_t pending_results [$];
    int   requests_sent = 0;
    int   fail_count = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    uart_rx_frame_manager i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // framer model: applies one request and returns the result it causes
    function automatic out_t frame_predict(input in_t req);
        out_t res;
        logic room;
        res = '0;
        case (opcode_t'(req.opcode))
            OP_RX_BYTE:
            begin
                if (cfg_bridge != 2'd0)
                begin
                    res.forward_valid = 1'b1;
                    res.forward_port  = cfg_bridge;
                    res.forward_byte  = req.rx_byte;
                end
                else
                begin
                    room = (fill < DEPTH);
                    if (room)
                    begin
                        line_mem[fill[7:0]] = req.rx_byte;
                        if (int'(fill) + 1 > written_top)
                            written_top = int'(fill) + 1;
                    end
                    if (cfg_term_en)
                    begin
                        // terminator ends the message even on a full buffer
                        if (req.rx_byte == cfg_term_char)
                        begin
                            fill = '0;
                            done = 1'b1;
                        end
                        else if (room)
                            fill = fill + 9'd1;
                        else
                            res.overflow = 1'b1;
                    end
                    else
                    begin
                        if (room)
                            fill = fill + 9'd1;
                        else
                            res.overflow = 1'b1;
                        idle_cnt = cfg_idle_ticks;
                        res.restart_timer = 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (fill != 9'd0)
                begin
                    if (idle_cnt == 16'd0)
                    begin
                        fill = '0;
                        done = 1'b1;
                        res.restart_timer = 1'b1;
                    end
                    else
                        idle_cnt = idle_cnt - 16'd1;
                end
            end
            OP_CLEAR:
                done = 1'b0;
            default:
            begin
                if (req.read_index < DEPTH)
                    res.read_data = line_mem[req.read_index];
            end
        endcase
        res.frame_done = done;
        res.fill_count = fill;
        return res;
    endfunction

    // request with random filler in the fields the opcode ignores
    function automatic in_t make_request(input opcode_t op, input logic [7:0] rx,
                                         input logic [7:0] idx);
        in_t req;
        req.opcode     = op;
        req.rx_byte    = (op == OP_RX_BYTE) ? rx : 8'($urandom);
        req.read_index = (op == OP_READ) ? idx : 8'($urandom);
        return req;
    endfunction

    // index of an entry already written since reset
    function automatic logic [7:0] written_index();
        return 8'($urandom_range(0, written_top - 1));
    endfunction

    // offer one request, with random gaps, and record its expected result
    task automatic send_request(input in_t req, input logic use_fixed, input out_t fixed_res);
        out_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = frame_predict(req);
        if (use_fixed)
            res = fixed_res;
        pending_results.push_back(res);
        requests_sent++;
    endtask

    task automatic send_op(input opcode_t op, input logic [7:0] rx, input logic [7:0] idx);
        send_request(make_request(op, rx, idx), 1'b0, '0);
    endtask

    // hold the sender until every pending result has come back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // register write on an idle block
    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BRIDGE_PORT: cfg_bridge     = val[1:0];
            REG_TERM_ENABLE: cfg_term_en    = val[0];
            REG_TERM_CHAR:   cfg_term_char  = val[7:0];
            default:         cfg_idle_ticks = val[15:0];
        endcase
    endtask

    // one random phase: new settings, then mostly whole messages plus noise, only noise in bridge mode
    task automatic run_segment(input int k, input int quota);
        int start;
        int len;
        int ticks;
        logic first;
        logic [7:0] b;
        opcode_t op;
        start = requests_sent;
        first = 1'b1;
        cfg_write(REG_BRIDGE_PORT, (k % 4 == 3) ? CFG_DATA_W'(k / 4 + 1) : '0);
        cfg_write(REG_TERM_ENABLE, CFG_DATA_W'(k % 2));
        cfg_write(REG_TERM_CHAR, (k == 1) ? 16'h0000 : (k == 5) ? 16'h00FF
                                           : CFG_DATA_W'($urandom_range(0, 255)));
        cfg_write(REG_IDLE_TICKS, (k == 2) ? 16'h0000 : (k == 6) ? 16'hFFFF
                                            : CFG_DATA_W'($urandom_range(0, 6)));
        while (requests_sent - start < quota)
        begin
            if ($urandom_range(0, 49) == 0)
                wait_until_drained();
            if (cfg_bridge == 2'd0 && $urandom_range(0, 99) < 70)
            begin
                // message body, long enough early on to fill the buffer past its end
                if (first && (k == 0 || k == 1 || k == 6))
                    len = $urandom_range(257, 262);
                else
                    len = $urandom_range(1, 16);
                repeat (len)
                begin
                    b = 8'($urandom);
                    if (cfg_term_en && b == cfg_term_char)
                        b = b ^ 8'h01;
                    send_op(OP_RX_BYTE, b, '0);
                end
                // message end
                if (cfg_term_en)
                    send_op(OP_RX_BYTE, cfg_term_char, '0);
                else
                begin
                    ticks = (cfg_idle_ticks < 10) ? int'(cfg_idle_ticks) + 1
                                                  : $urandom_range(1, 4);
                    repeat (ticks) send_op(OP_TICK, '0, '0);
                end
                // read back and acknowledge
                repeat ($urandom_range(0, 3)) send_op(OP_READ, '0, written_index());
                if ($urandom_range(0, 1) == 1)
                    send_op(OP_CLEAR, '0, '0);
                first = 1'b0;
            end
            else
            begin
                // noise
                op = opcode_t'($urandom_range(0, 3));
                if (op == OP_READ && written_top == 0)
                    op = OP_TICK;
                send_op(op, 8'($urandom), (op == OP_READ) ? written_index() : 8'h00);
            end
        end
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    endtask

    // receiver stall
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // result check against the oldest pending expectation
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_field("unexpected result, fill_count", 0, out_data.fill_count);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.forward_valid !== want.forward_valid)
                    report_field("forward_valid", want.forward_valid, out_data.forward_valid);
                if (out_data.forward_port !== want.forward_port)
                    report_field("forward_port", want.forward_port, out_data.forward_port);
                if (out_data.forward_byte !== want.forward_byte)
                    report_field("forward_byte", want.forward_byte, out_data.forward_byte);
                if (out_data.frame_done !== want.frame_done)
                    report_field("frame_done", want.frame_done, out_data.frame_done);
                if (out_data.fill_count !== want.fill_count)
                    report_field("fill_count", want.fill_count, out_data.fill_count);
                if (out_data.restart_timer !== want.restart_timer)
                    report_field("restart_timer", want.restart_timer, out_data.restart_timer);
                if (out_data.overflow !== want.overflow)
                    report_field("overflow", want.overflow, out_data.overflow);
                if (out_data.read_data !== want.read_data)
                    report_field("read_data", want.read_data, out_data.read_data);
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t row;
        out_t fixed_res;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        send_idle_pct = 28;
        recv_idle_pct = 60;
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED_STEPS[i];
            if (row.kind == ROW_CFG)
                cfg_write(cfg_index_t'(row.code), row.value);
            else
            begin
                fixed_res = '0;
                fixed_res.frame_done    = row.done;
                fixed_res.fill_count    = row.count;
                fixed_res.restart_timer = row.restart;
                fixed_res.read_data     = row.rdata;
                send_request(make_request(opcode_t'(row.code), row.value[7:0], row.index),
                             row.kind == ROW_FIXED, fixed_res);
            end
        end

        // random phases: sender light, then receiver light, then no idling
        for (int k = 0; k < SEGMENTS; k++)
        begin
            send_idle_pct = (k < 4) ? 28 : (k < 8) ? 60 : 0;
            recv_idle_pct = (k < 4) ? 60 : (k < 8) ? 28 : 0;
            run_segment(k, SEGMENT_REQUESTS);
        end

        wait_until_drained();
        repeat (6) @(posedge clk);
        if (pending_results.size() != 0)
            report_field("results still pending", 0, pending_results.size());
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
src/urfm_pkg.sv
src/urfm_ram.sv
src/urfm_ctrl.sv
src/urfm_out.sv
src/uart_rx_frame_manager.sv
verif/uart_rx_frame_manager_tb.sv
